>>> rtl/wmaf_pkg.sv
package wmaf_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int WINDOW_DEF      = 64;
   localparam int MIN_HISTORY_DEF = 6;

   // request action codes
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUSH,
      ST_LOAD,
      ST_DIVIDE,
      ST_OUT
   } state_type;

   // history control from the sequencer
   typedef struct packed {
      logic clear;
      logic push;
   } hist_ctl_type;

endpackage

>>> rtl/wmaf_if.sv
interface wmaf_req_if
   import wmaf_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

interface wmaf_rsp_if
   import wmaf_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic signed [SAMPLE_W-1:0] window_min;

   modport source (output valid, output filtered, output window_min, input ready);
   modport sink   (input valid, input filtered, input window_min, output ready);
endinterface

>>> rtl/wmaf_cell.sv
module wmaf_cell
   import wmaf_pkg::*;
#(
   parameter int INDEX  = 0,
   parameter int FILL_W = 7
) (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [FILL_W-1:0]          fill_count,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic signed [SAMPLE_W-1:0] min_in,
   output logic signed [SAMPLE_W-1:0] sample_out,
   output logic signed [SAMPLE_W-1:0] min_out
);

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in_nx;
   logic signed [SAMPLE_W-1:0] min_ff, min_in_nx;
   logic                       active;

   // cell holds a live sample only below the fill level
   assign active = (fill_count > FILL_W'(INDEX));

   always_comb begin
      sample_in_nx = shift_en ? sample_in : sample_ff;
      min_in_nx    = (active && (sample_ff < min_in)) ? sample_ff : min_in;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_nx;
      min_ff    <= min_in_nx;
   end

   assign sample_out = sample_ff;
   assign min_out    = min_ff;

endmodule

>>> rtl/wmaf_hist.sv
module wmaf_hist
   import wmaf_pkg::*;
#(
   parameter int MIN_HISTORY = MIN_HISTORY_DEF,
   parameter int SUM_W       = SAMPLE_W + $clog2(MIN_HISTORY)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hist_ctl_type               ctl,
   input  logic                       ignore_same,
   input  logic signed [SAMPLE_W-1:0] min_value,
   output logic signed [SUM_W-1:0]    sum
);

   logic signed [SAMPLE_W-1:0] hist_ff [MIN_HISTORY];
   logic signed [SAMPLE_W-1:0] hist_in [MIN_HISTORY];
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       push_eff;

   // equal-to-newest minimum is dropped when ignore_same is set
   assign push_eff = ctl.push &&
                     !(ignore_same && (hist_ff[MIN_HISTORY-1] == min_value));

   always_comb begin
      for (int i = 0; i < MIN_HISTORY; i++) begin
         hist_in[i] = hist_ff[i];
      end
      sum_in = sum_ff;
      if (ctl.clear) begin
         for (int i = 0; i < MIN_HISTORY; i++) begin
            hist_in[i] = '0;
         end
         sum_in = '0;
      end else if (push_eff) begin
         for (int i = 0; i + 1 < MIN_HISTORY; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[MIN_HISTORY-1] = min_value;
         // running sum: add newest, drop oldest
         sum_in = sum_ff + SUM_W'(min_value) - SUM_W'(hist_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MIN_HISTORY; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else begin
         for (int i = 0; i < MIN_HISTORY; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> rtl/wmaf_div.sv
module wmaf_div
   import wmaf_pkg::*;
#(
   parameter int MIN_HISTORY = MIN_HISTORY_DEF,
   parameter int SUM_W       = SAMPLE_W + $clog2(MIN_HISTORY)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] quotient
);

   // floor(mag * RECIP / 2^SHIFT) == floor(mag / MIN_HISTORY) for any
   // SUM_W-bit magnitude when SHIFT = SUM_W + clog2(MIN_HISTORY)
   localparam int LOG_D   = $clog2(MIN_HISTORY);
   localparam int SHIFT   = SUM_W + LOG_D;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int Q_W     = PROD_W - SHIFT;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << SHIFT) + longint'(MIN_HISTORY) - longint'(1))
               / longint'(MIN_HISTORY));

   logic [SUM_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic                      busy_ff, busy_in;
   logic signed [SAMPLE_W-1:0] quot_ff, quot_in;
   logic [PROD_W-1:0]         prod;
   logic [Q_W-1:0]            mag_q;
   logic [Q_W-1:0]            q_signed;

   // reciprocal multiply on the magnitude, sign put back after
   assign prod     = PROD_W'(mag_ff) * PROD_W'(RECIP);
   assign mag_q    = prod[PROD_W-1:SHIFT];
   // sign-magnitude gives truncation toward zero
   assign q_signed = neg_ff ? (Q_W'(0) - mag_q) : mag_q;

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      quot_in = quot_ff;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = q_signed[SAMPLE_W-1:0];
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;
   assign busy     = busy_ff;

endmodule

>>> rtl/window_min_then_average_filter.sv
// Sliding-window minimum filter followed by a moving average of minima.
// Each filter transaction shifts its sample into a row of WINDOW cells; the
// minimum over the filled cells is found by a token that walks the row one
// cell per cycle. After the walk over the cell row come the min capture, the
// history push, the divide by MIN_HISTORY (a reciprocal multiply: start, then
// the busy step, then a handoff), the output load and the idle state that
// takes the next request. A clear transaction is handled in the idle state
// and gives no response. One request is worked at a time; req ready is high
// only while the block waits for work. A finished response sits in an output
// register until taken, and the next request is accepted meanwhile.
// ignore_same is written through csr_we / csr_wdata; the user must write it
// only while the block is idle, which the block itself leaves unenforced.
module window_min_then_average_filter
   import wmaf_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int MIN_HISTORY = MIN_HISTORY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wmaf_req_if.sink    req_chan,
   wmaf_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int CNT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = SAMPLE_W + $clog2(MIN_HISTORY);

   state_type state_ff, state_in;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              ignore_same_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic signed [SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;

   logic req_fire, shift_en, div_start, div_busy;
   hist_ctl_type hist_ctl;

   logic signed [SAMPLE_W-1:0] chain_sample [WINDOW];
   logic signed [SAMPLE_W-1:0] chain_min    [WINDOW];
   logic signed [SUM_W-1:0]    hist_sum;
   logic signed [SAMPLE_W-1:0] div_q;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign shift_en       = req_fire && (req_chan.action == ACT_FILTER);

   // cell row: newest sample enters cell 0, the min token walks to the far end
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         wmaf_cell #(.INDEX(i), .FILL_W(FILL_W)) u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .fill_count (fill_ff),
            .sample_in  (req_chan.sample),
            .min_in     (chain_sample[0]),
            .sample_out (chain_sample[i]),
            .min_out    (chain_min[i])
         );
      end else begin : g_body
         wmaf_cell #(.INDEX(i), .FILL_W(FILL_W)) u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .fill_count (fill_ff),
            .sample_in  (chain_sample[i-1]),
            .min_in     (chain_min[i-1]),
            .sample_out (chain_sample[i]),
            .min_out    (chain_min[i])
         );
      end
   end

   wmaf_hist #(.MIN_HISTORY(MIN_HISTORY), .SUM_W(SUM_W)) u_hist (
      .clock       (clock),
      .reset       (reset),
      .ctl         (hist_ctl),
      .ignore_same (ignore_same_ff),
      .min_value   (min_ff),
      .sum         (hist_sum)
   );

   wmaf_div #(.MIN_HISTORY(MIN_HISTORY), .SUM_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hist_sum),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // sequencer: next state and controls
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      scan_in         = scan_ff;
      min_in          = min_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_min_in      = rsp_min_ff;
      hist_ctl        = '0;
      // divide starts the cycle after the history push lands
      div_start       = (state_ff == ST_DIVIDE) && !div_busy && (scan_ff != '0);
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_fire) begin
               if (req_chan.action == ACT_CLEAR) begin
                  fill_in        = '0;
                  hist_ctl.clear = 1'b1;
               end else begin
                  if (fill_ff != FILL_W'(WINDOW)) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            if (scan_ff == CNT_W'(WINDOW - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // token has reached the last cell
            min_in   = chain_min[WINDOW-1];
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            hist_ctl.push = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy && !div_start) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = div_q;
               rsp_min_in      = min_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         scan_ff        <= '0;
         ignore_same_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_DIVIDE && div_start) begin
            scan_ff <= '0;
         end else if (state_ff == ST_LOAD) begin
            scan_ff <= CNT_W'(1);
         end else begin
            scan_ff <= scan_in;
         end
         if (csr_we) begin
            ignore_same_ff <= csr_wdata;
         end
      end
      min_ff          <= min_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_min_ff      <= rsp_min_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.filtered   = rsp_filtered_ff;
   assign rsp_chan.window_min = rsp_min_ff;

endmodule

>>> dv/wmaf_checker.sv
`timescale 1ns / 1ps

// Scoreboard for window_min_then_average_filter: predicts each response
// from the accepted requests and compares it with what the block returns.
module wmaf_checker
   import wmaf_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int MIN_HISTORY = MIN_HISTORY_DEF
) (
   input  logic clock,
   input  logic reset,
   wmaf_req_if  req_mon,
   wmaf_rsp_if  rsp_mon,
   input  logic csr_we,
   input  logic csr_wdata,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic signed [SAMPLE_W-1:0] window_min;
   } avg_result_type;

   logic signed [SAMPLE_W-1:0] win_cells [WINDOW];
   logic signed [SAMPLE_W-1:0] min_hist  [MIN_HISTORY];
   int                         filled;
   logic                       skip_same;
   avg_result_type             expected_avgs [$];
   int                         n_fail;
   int                         n_checked;

   function automatic void clear_filter();
      filled = 0;
      for (int i = 0; i < MIN_HISTORY; i++) min_hist[i] = '0;
   endfunction

   function automatic avg_result_type filter_sample(input logic signed [SAMPLE_W-1:0] s);
      logic signed [SAMPLE_W-1:0] mn;
      int                         sum;
      avg_result_type             r;
      if (filled < WINDOW) begin
         win_cells[filled] = s;
         filled++;
      end else begin
         for (int i = 0; i < WINDOW - 1; i++) win_cells[i] = win_cells[i + 1];
         win_cells[WINDOW - 1] = s;
      end
      mn = win_cells[0];
      for (int i = 1; i < filled; i++)
         if (win_cells[i] < mn) mn = win_cells[i];
      // repeated minimum leaves the history alone when skip_same is set
      if (!(skip_same && min_hist[MIN_HISTORY - 1] == mn)) begin
         for (int i = 0; i < MIN_HISTORY - 1; i++) min_hist[i] = min_hist[i + 1];
         min_hist[MIN_HISTORY - 1] = mn;
      end
      sum = 0;
      for (int i = 0; i < MIN_HISTORY; i++) sum += min_hist[i];
      r.filtered   = SAMPLE_W'(sum / MIN_HISTORY);
      r.window_min = mn;
      return r;
   endfunction

   always @(posedge clock) begin : mon_proc
      avg_result_type got;
      avg_result_type want;
      if (reset) begin
         clear_filter();
         skip_same = 1'b0;
         expected_avgs.delete();
         n_fail    = 0;
         n_checked = 0;
      end else begin
         if (csr_we) skip_same = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_CLEAR) clear_filter();
            else expected_avgs.push_back(filter_sample(req_mon.sample));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.filtered   = rsp_mon.filtered;
            got.window_min = rsp_mon.window_min;
            if (expected_avgs.size() == 0) begin
               $error("unexpected response: filtered %0d, window_min %0d",
                      got.filtered, got.window_min);
               n_fail++;
            end else begin
               want = expected_avgs.pop_front();
               n_checked++;
               if (got.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d", want.filtered, got.filtered);
                  n_fail++;
               end
               if (got.window_min !== want.window_min) begin
                  $error("window_min: expected %0d, actual %0d",
                         want.window_min, got.window_min);
                  n_fail++;
               end
            end
         end
      end
      fail_count <= n_fail;
      checked    <= n_checked;
      pending    <= expected_avgs.size();
   end

endmodule

>>> dv/tb_window_min_then_average_filter.sv
`timescale 1ns / 1ps

module tb_window_min_then_average_filter
   import wmaf_pkg::*;
   ;

   localparam int CLK_HALF     = 4;       // 8 ns period
   localparam int RESET_CYCLES = 7;
   // outlasts the time one sample occupies the block; wait this long
   // before touching the register or ending the run
   localparam int DRAIN_CYCLES = 128;
   // leave a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 325;
   localparam int QUIET_AFTER  = 1150;    // no idling from here on

   // how a run of random samples is shaped
   typedef enum int {
      SHAPE_FULL,       // any 16-bit value
      SHAPE_EXTREME,    // rails, zero and minus one
      SHAPE_NARROW,     // tiny range, so minima repeat
      SHAPE_RISE,       // ramp up: oldest sample stays the minimum until evicted
      SHAPE_FALL        // ramp down: each sample is a new minimum
   } shape_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   wmaf_req_if req_bus ();
   wmaf_rsp_if rsp_bus ();

   int  chk_fails;
   int  chk_pending;
   int  chk_checked;
   int  cycle_count = 0;
   int  sent_items  = 0;
   int  clear_items = 0;
   int  cfg_writes  = 0;
   bit  quiet       = 1'b0;   // idling off on both sides
   bit  tx_gaps     = 1'b0;   // sender may insert idle bursts

   window_min_then_average_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   wmaf_checker u_filter_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (chk_fails),
      .pending    (chk_pending),
      .checked    (chk_checked)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** window_min_then_average_filter: FAILED **");
         $finish;
      end
   end

   // Response side: ready drops in random bursts. The burst mode is re-drawn on
   // cycle_count boundaries, so some stretches run with no stalls at all.
   initial begin : rsp_sink
      int  stall_left;
      bit  rx_stalls;
      stall_left = 0;
      rx_stalls  = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_count % 256 == 0) rx_stalls = ($urandom_range(0, 2) != 0);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!quiet && rx_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Drive one request transaction and hold it until accepted. valid is
   // lowered here only for an idle burst, so it never gets two updates in one step.
   task automatic send_item(input logic act, input logic signed [SAMPLE_W-1:0] smp);
      if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.sample <= smp;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
      if (act == ACT_CLEAR) clear_items++;
   endtask

   // Register write only with the block idle: every response in, and then a
   // full sample latency so a trailing clear has surely finished too.
   task automatic write_skip_same(input logic val);
      req_bus.valid <= 1'b0;
      while (chk_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_writes++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] shape_sample(
      input shape_type                  shape,
      input int                         k,
      input logic signed [SAMPLE_W-1:0] base,
      input int                         step
   );
      case (shape)
         SHAPE_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         SHAPE_NARROW: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
         SHAPE_RISE:   return SAMPLE_W'(int'(base) + k * step);
         SHAPE_FALL:   return SAMPLE_W'(int'(base) - k * step);
         default:      return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Random traffic: runs of filter samples with random content, mostly short
   // but some longer than the window so eviction is exercised; clears between
   // runs, sometimes none and sometimes two back to back.
   task automatic run_random_phase(input int n_items);
      int                         start;
      int                         run_len;
      int                         step;
      shape_type                  shape;
      logic signed [SAMPLE_W-1:0] base;
      start = sent_items;
      while (sent_items - start < n_items) begin
         tx_gaps = ($urandom_range(0, 3) != 0);
         if (sent_items >= QUIET_AFTER) quiet = 1'b1;
         run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 140)
                                               : $urandom_range(1, 20);
         shape = shape_type'($urandom_range(0, 4));
         base  = SAMPLE_W'($urandom);
         step  = $urandom_range(1, 300);
         for (int k = 0; k < run_len; k++)
            send_item(ACT_FILTER, shape_sample(shape, k, base, step));
         case ($urandom_range(0, 5))
            0, 1: ;
            2: begin
               send_item(ACT_CLEAR, SAMPLE_W'($urandom));
               send_item(ACT_CLEAR, SAMPLE_W'($urandom));
            end
            default: send_item(ACT_CLEAR, SAMPLE_W'($urandom));
         endcase
      end
   endtask

   initial begin : stimulus
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= 1'b0;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_FILTER;
      req_bus.sample <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed, pushing every minimum
      write_skip_same(1'b0);
      tx_gaps = 1'b1;
      // rails and values around zero against the zero history from reset
      send_item(ACT_FILTER, 16'sh7FFF);
      send_item(ACT_FILTER, 16'sh8000);
      send_item(ACT_FILTER, 16'sh0000);
      send_item(ACT_FILTER, 16'sh0001);
      send_item(ACT_FILTER, 16'shFFFF);
      // clear, then fill the history with the most negative minimum
      send_item(ACT_CLEAR, 16'sh0000);
      repeat (6) send_item(ACT_FILTER, 16'sh8000);
      // clear, then the most positive minimum throughout
      send_item(ACT_CLEAR, 16'shFFFF);
      repeat (6) send_item(ACT_FILTER, 16'sh7FFF);

      // directed, skipping repeated minima
      write_skip_same(1'b1);
      send_item(ACT_FILTER, 16'sh0005);
      send_item(ACT_FILTER, 16'sh0005);   // same minimum: history holds
      send_item(ACT_CLEAR, 16'sh1234);
      send_item(ACT_FILTER, 16'sh0000);   // equals the zero left by the clear

      // random phases, alternating the register
      write_skip_same(1'b0);
      run_random_phase(PHASE_ITEMS);
      write_skip_same(1'b1);
      run_random_phase(PHASE_ITEMS);
      write_skip_same(1'b0);
      run_random_phase(PHASE_ITEMS);
      write_skip_same(1'b1);
      run_random_phase(PHASE_ITEMS);

      // drain: every response in, then DRAIN_CYCLES of quiet
      req_bus.valid <= 1'b0;
      while (chk_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request transactions (%0d clears) over %0d register writes",
               sent_items, clear_items, cfg_writes);
      $display("checked %0d responses, %0d mismatches", chk_checked, chk_fails);
      if (chk_fails == 0 && chk_pending == 0) begin
         $display("** window_min_then_average_filter: PASSED **");
      end else begin
         $display("** window_min_then_average_filter: FAILED **");
      end
      $finish;
   end

endmodule
